// ===== src/wmsh_pkg.sv =====
// Shared types, constants and mixing functions for the word-mix string hash.
package wmsh_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int CNT_W  = 4;

    // Mix multiplier 0x9999999999999999; both 32-bit halves are equal.
    localparam logic [HALF_W-1:0] MULT_HALF = 32'h9999_9999;
    localparam logic [CNT_W-1:0]  FULL_BYTES = 4'd8;

    // One classified item queued between front and back.
    typedef struct packed {
        logic [WORD_W-1:0] pre_mix; // word after tail shift and rotate-xor
        logic              first;
        logic              last;
        logic              empty;   // empty string marker
    } t_item;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ACC  = 5'b00100,
        S_FMUL = 5'b01000,
        S_FFIN = 5'b10000
    } t_state;

    // a ^ rotl(a,21) ^ rotr(a,21)
    function automatic logic [WORD_W-1:0] f_rot_xor(input logic [WORD_W-1:0] a);
        return a ^ {a[42:0], a[63:43]} ^ {a[20:0], a[63:21]};
    endfunction

    // Shift-xor applied to the running hash.
    function automatic logic [WORD_W-1:0] f_state_mix(input logic [WORD_W-1:0] a);
        logic [WORD_W-1:0] t;
        t = a ^ (a >> 7);
        return t ^ (t << 9);
    endfunction

    function automatic logic [WORD_W-1:0] f_byte_swap(input logic [WORD_W-1:0] a);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = a[8*(7-i) +: 8];
        end
        return r;
    endfunction

endpackage

// ===== src/wmsh_front.sv =====
// Front end: applies tail shift and rotate-xor, classifies the item for the queue.
module wmsh_front
    import wmsh_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    input  logic [CNT_W-1:0]  i_count,
    input  logic              i_first,
    input  logic              i_last,
    output t_item             o_item
);

    logic [CNT_W-1:0]  w_k;
    logic [5:0]        w_shift;
    logic [WORD_W-1:0] w_word;
    logic              w_empty;

    always_comb begin
        // counts above eight saturate; non-first words are never shifted
        if (!i_first || i_count > FULL_BYTES) begin
            w_k = FULL_BYTES;
        end else begin
            w_k = i_count;
        end
        w_empty = i_first && (i_count == '0);
        w_shift = (w_k == '0) ? 6'd0 : {3'(FULL_BYTES - w_k), 3'b000};
        w_word  = i_word >> w_shift;

        o_item.pre_mix = f_rot_xor(w_word);
        o_item.first   = i_first;
        o_item.last    = i_last;
        o_item.empty   = w_empty;
    end

endmodule

// ===== src/wmsh_fifo.sv =====
// Short item queue between the front end and the mixing back end.
module wmsh_fifo
    import wmsh_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count != '0)
        else $error("queue count wrapped on push");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue popped while empty");
`endif

endmodule

// ===== src/wmsh_back.sv =====
// Back end: shared split multiplier, running hash update, finalize and output register.
module wmsh_back
    import wmsh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_item             i_item,
    input  logic              i_avail,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_hash
);

    t_state            r_state, n_state;
    t_item             r_cur;
    logic [WORD_W-1:0] r_mop, n_mop;
    logic [WORD_W-1:0] r_plo;
    logic [HALF_W-1:0] r_px;
    logic [WORD_W-1:0] r_hash, n_hash;
    logic              r_zero, n_zero;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_data, n_out_data;

    logic [HALF_W-1:0] w_sum;
    logic [WORD_W-1:0] w_plo;
    logic [HALF_W-1:0] w_px;
    logic [WORD_W-1:0] w_prod;
    logic              w_out_free;

    // x * C mod 2^64 with equal halves of C: lo*Ch + ((lo+hi)*Ch << 32)
    assign w_sum  = r_mop[HALF_W-1:0] + r_mop[WORD_W-1:HALF_W];
    assign w_plo  = WORD_W'(r_mop[HALF_W-1:0]) * WORD_W'(MULT_HALF);
    assign w_px   = HALF_W'(w_sum * MULT_HALF);
    assign w_prod = r_plo + {r_px, {HALF_W{1'b0}}};

    assign w_out_free = !r_out_valid || i_ready;
    assign o_pop      = (r_state == S_IDLE) && i_avail;
    assign o_valid    = r_out_valid;
    assign o_hash     = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_mop       = r_mop;
        n_hash      = r_hash;
        n_zero      = r_zero;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;
        case (r_state)
            S_IDLE: begin
                if (i_avail) begin
                    n_mop   = i_item.pre_mix;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_cur.empty) begin
                    n_hash = '0;
                end else if (r_cur.first) begin
                    n_hash = w_prod;
                end else begin
                    n_hash = f_state_mix(r_hash) + w_prod;
                end
                if (r_cur.last) begin
                    n_zero  = r_cur.empty;
                    n_mop   = f_byte_swap(n_hash);
                    n_state = S_FMUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FMUL: begin
                n_state = S_FFIN;
            end
            S_FFIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_zero ? '0 : w_prod;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_item;
        end
        r_mop      <= n_mop;
        r_plo      <= w_plo;
        r_px       <= w_px;
        r_zero     <= n_zero;
        r_out_data <= n_out_data;
    end

`ifndef SYNTHESIS
    a_fmul_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FMUL |-> $past(r_state) == S_ACC)
        else $error("finalize multiply entered out of sequence");
    a_out_from_ffin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FFIN)
        else $error("result loaded outside finalize");
    a_acc_hash_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_FMUL) |=> $stable(r_hash))
        else $error("running hash changed outside accumulate");
`endif

endmodule

// ===== src/word_mix_string_hash.sv =====
// Top level of the word-mix string hash: front end, item queue and mixing back end.
//
// Usage: software streams a string as 64-bit little-endian words from its end
// toward its start. Slave item: tdata[63:0] data word, tdata[67:64] tail byte
// count (first item only, 0 = empty string), tuser = first item of a string,
// tlast = word at the string's start. The block answers each tlast item with
// one 64-bit hash on the master channel (0 for the empty string).
// The front end shifts and rotate-xors the word and queues it; the back end
// owns one split multiplier (two 32x32 products) that serves both the word
// mix and the final mix, so an item occupies it through states S_MUL and
// S_ACC, and a tlast item also through S_FMUL and S_FFIN. The back end pops
// a new item only in S_IDLE, after the running-hash update of the last one.
// In S_FFIN the result is loaded into the output register that drives tvalid.
// The queue lets the slave side accept up to QUEUE_DEPTH items ahead of the back
// end. When the receiver stalls, the result waits in the output register and
// the back end keeps working until it reaches the next finalize step.
// Reset (synchronous, active low) clears the running hash to zero, empties the
// queue and drops any pending result.
module word_mix_string_hash
    import wmsh_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [63:0] data_word, [67:64] valid_bytes, rest 0
    input  logic        s_axis_tuser,   // [0] is_first
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] hash_value
);

    t_item w_front_item;
    t_item w_queue_item;
    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;

    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && !w_full;

    wmsh_front u_front (
        .i_word  (s_axis_tdata[WORD_W-1:0]),
        .i_count (s_axis_tdata[WORD_W +: CNT_W]),
        .i_first (s_axis_tuser),
        .i_last  (s_axis_tlast),
        .o_item  (w_front_item)
    );

    wmsh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_queue_item),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    wmsh_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_queue_item),
        .i_avail (!w_empty),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_hash  (m_axis_tdata)
    );

endmodule
